### rtl/core/gvd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gvd_pkg: shared types and codes for the degree-bucket graph block
// Field widths, request and status codes, and the degree unit's command set.
// ----------------------------------------------------------------------------
package gvd_pkg;

   localparam int MAX_VERTICES_DEF = 64;

   localparam int REQ_TYPE_W = 2;
   localparam int VERTEX_W   = 6;
   localparam int STATUS_W   = 2;
   localparam int COUNT_W    = 7;
   localparam int BKT_W      = 2;

   localparam int NUM_BUCKETS = 4;
   localparam int TOP_BUCKET  = 3;

   localparam logic [COUNT_W-1:0] VERTEX_COUNT_RST = 7'd64;

   // request codes
   localparam logic [REQ_TYPE_W-1:0] REQ_RESET_GRAPH      = 2'd0;
   localparam logic [REQ_TYPE_W-1:0] REQ_INSERT_EDGE      = 2'd1;
   localparam logic [REQ_TYPE_W-1:0] REQ_DELETE_VERTEX    = 2'd2;
   localparam logic [REQ_TYPE_W-1:0] REQ_DELETE_NEIGHBORS = 2'd3;

   // status codes
   localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_ABSENT    = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_SELF_LOOP = 2'd2;

   // degree unit commands
   typedef logic [2:0] gvd_op_type;
   localparam gvd_op_type UPD_NONE = 3'd0;
   localparam gvd_op_type UPD_LOAD = 3'd1;
   localparam gvd_op_type UPD_INC  = 3'd2;
   localparam gvd_op_type UPD_DEC  = 3'd3;
   localparam gvd_op_type UPD_DROP = 3'd4;

   typedef struct packed {
      logic [COUNT_W-1:0] present;
      logic [COUNT_W-1:0] deg0;
      logic [COUNT_W-1:0] deg1;
      logic [COUNT_W-1:0] deg2;
      logic [COUNT_W-1:0] deg3plus;
   } gvd_counts_type;

endpackage

### rtl/core/gvd_req_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gvd_req_if: request channel
// Valid/ready channel carrying one graph request.
// ----------------------------------------------------------------------------
interface gvd_req_if;
   import gvd_pkg::*;

   logic                  valid;
   logic                  ready;
   logic [REQ_TYPE_W-1:0] req_type;
   logic [VERTEX_W-1:0]   vertex;
   logic [VERTEX_W-1:0]   other_vertex;

   modport source (output valid, req_type, vertex, other_vertex, input ready);
   modport sink   (input valid, req_type, vertex, other_vertex, output ready);
endinterface

### rtl/core/gvd_rsp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gvd_rsp_if: response channel
// Valid/ready channel carrying status, removal count and bucket counts.
// ----------------------------------------------------------------------------
interface gvd_rsp_if;
   import gvd_pkg::*;

   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [COUNT_W-1:0]  removed_count;
   logic [COUNT_W-1:0]  present_count;
   logic [COUNT_W-1:0]  degree0_count;
   logic [COUNT_W-1:0]  degree1_count;
   logic [COUNT_W-1:0]  degree2_count;
   logic [COUNT_W-1:0]  degree3plus_count;

   modport source (output valid, status, removed_count, present_count, degree0_count,
                   degree1_count, degree2_count, degree3plus_count, input ready);
   modport sink   (input valid, status, removed_count, present_count, degree0_count,
                   degree1_count, degree2_count, degree3plus_count, output ready);
endinterface

### rtl/core/gvd_csr_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gvd_csr_if: configuration write channel
// Valid/ready channel writing the vertex count register.
// ----------------------------------------------------------------------------
interface gvd_csr_if;
   import gvd_pkg::*;

   logic               valid;
   logic               ready;
   logic [COUNT_W-1:0] vertex_count;

   modport source (output valid, vertex_count, input ready);
   modport sink   (input valid, vertex_count, output ready);
endinterface

### rtl/core/gvd_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gvd_ram: generic single-write, single-read RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module gvd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

### rtl/core/gvd_degree_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gvd_degree_unit: shared degree step and bucket bookkeeping
// Steps a degree by one up or down, moving the vertex between degree buckets,
// drops or loads vertices; keeps the present total and four bucket counters.
// ----------------------------------------------------------------------------
module gvd_degree_unit #(
   parameter int MAX_VERTICES = gvd_pkg::MAX_VERTICES_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  gvd_pkg::gvd_op_type                 upd_op,
   input  logic [$clog2(MAX_VERTICES)-1:0]     deg_in,
   input  logic [$clog2(MAX_VERTICES+1)-1:0]   load_count,
   output logic [$clog2(MAX_VERTICES)-1:0]     deg_out,
   output gvd_pkg::gvd_counts_type             counts
);
   import gvd_pkg::*;

   localparam int DEG_W = $clog2(MAX_VERTICES);
   localparam int CNT_W = $clog2(MAX_VERTICES + 1);

   logic [CNT_W-1:0] bucket_ff [NUM_BUCKETS];
   logic [CNT_W-1:0] bucket_in [NUM_BUCKETS];
   logic [CNT_W-1:0] present_ff;
   logic [CNT_W-1:0] present_in;
   logic [BKT_W-1:0] old_bkt;
   logic [BKT_W-1:0] new_bkt;
   logic             take;
   logic             give;

   function automatic logic [BKT_W-1:0] bucket_of(input logic [DEG_W-1:0] deg);
      bucket_of = (deg >= DEG_W'(TOP_BUCKET)) ? BKT_W'(TOP_BUCKET) : deg[BKT_W-1:0];
   endfunction

   assign deg_out = (upd_op == UPD_INC) ? deg_in + DEG_W'(1) : deg_in - DEG_W'(1);
   assign old_bkt = bucket_of(deg_in);
   assign new_bkt = bucket_of(deg_out);
   assign take    = (upd_op == UPD_INC) || (upd_op == UPD_DEC) || (upd_op == UPD_DROP);
   assign give    = (upd_op == UPD_INC) || (upd_op == UPD_DEC);

   always_comb begin
      present_in = present_ff;
      for (int b = 0; b < NUM_BUCKETS; b++) begin
         bucket_in[b] = bucket_ff[b];
      end
      unique case (upd_op)
         UPD_LOAD: begin
            present_in = load_count;
            for (int b = 0; b < NUM_BUCKETS; b++) begin
               bucket_in[b] = (b == 0) ? load_count : '0;
            end
         end
         UPD_INC, UPD_DEC, UPD_DROP: begin
            for (int b = 0; b < NUM_BUCKETS; b++) begin
               bucket_in[b] = bucket_ff[b]
                            - CNT_W'(take && (old_bkt == BKT_W'(b)))
                            + CNT_W'(give && (new_bkt == BKT_W'(b)));
            end
            if (upd_op == UPD_DROP) begin
               present_in = present_ff - CNT_W'(1);
            end
         end
         default: begin
            present_in = present_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         present_ff <= '0;
         for (int b = 0; b < NUM_BUCKETS; b++) begin
            bucket_ff[b] <= '0;
         end
      end else begin
         present_ff <= present_in;
         for (int b = 0; b < NUM_BUCKETS; b++) begin
            bucket_ff[b] <= bucket_in[b];
         end
      end
   end

   assign counts.present  = COUNT_W'(present_ff);
   assign counts.deg0     = COUNT_W'(bucket_ff[0]);
   assign counts.deg1     = COUNT_W'(bucket_ff[1]);
   assign counts.deg2     = COUNT_W'(bucket_ff[2]);
   assign counts.deg3plus = COUNT_W'(bucket_ff[3]);

`ifndef SYNTHESIS
   a_buckets_sum: assert property (@(posedge clock) disable iff (reset)
      (CNT_W+2)'(bucket_ff[0]) + (CNT_W+2)'(bucket_ff[1]) + (CNT_W+2)'(bucket_ff[2])
         + (CNT_W+2)'(bucket_ff[3]) == (CNT_W+2)'(present_ff))
      else $error("bucket counts do not add up to the present total");

   a_drop_nonempty: assert property (@(posedge clock) disable iff (reset)
      (upd_op == UPD_DROP) |-> (present_ff != '0))
      else $error("vertex dropped from an empty graph");

   a_dec_nonzero: assert property (@(posedge clock) disable iff (reset)
      (upd_op == UPD_DEC) |-> (deg_in != '0))
      else $error("degree stepped below zero");
`endif
endmodule

### rtl/core/graph_vertex_deletion_degree_buckets.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// graph_vertex_deletion_degree_buckets: undirected graph with vertex deletion
// Keeps adjacency rows, present flags, degrees and degree-bucket counts and
// answers every request with one response.
// ----------------------------------------------------------------------------
// One request is in flight at a time; req_ch.ready is high only while idle,
// and a finished response waits in an output register so the next request
// can be taken before it is collected. Deleting a vertex walks its
// adjacency row one bit per cycle and visits each neighbor in a further
// state that clears the victim from its row and steps its degree down.
// Deleting the neighbors of a vertex scans that vertex's row one bit per
// cycle while no delete is running, and runs the vertex delete for each
// present neighbor. The vertex table (adjacency row plus degree per
// vertex, one read port and one write port) and the one shared degree
// unit set the pace of every request. The table's rows carry valid bits
// in flip-flops, so a graph reset clears it by clearing those bits, with
// no sweep. The vertex count register may be written whenever the
// block is idle.
// ----------------------------------------------------------------------------
module graph_vertex_deletion_degree_buckets #(
   parameter int MAX_VERTICES = gvd_pkg::MAX_VERTICES_DEF
) (
   input  logic      clock,
   input  logic      reset,
   gvd_req_if.sink   req_ch,
   gvd_rsp_if.source rsp_ch,
   gvd_csr_if.sink   csr_ch
);
   import gvd_pkg::*;

   localparam int VX_W  = $clog2(MAX_VERTICES);
   localparam int DEG_W = VX_W;
   localparam int CNT_W = $clog2(MAX_VERTICES + 1);
   localparam int ENT_W = MAX_VERTICES + DEG_W;

   // sequencer states
   localparam logic [3:0] S_IDLE    = 4'd0;
   localparam logic [3:0] S_CHECK   = 4'd1;
   localparam logic [3:0] S_INS_A   = 4'd2;
   localparam logic [3:0] S_INS_B   = 4'd3;
   localparam logic [3:0] S_NB_LOAD = 4'd4;
   localparam logic [3:0] S_NB_SCAN = 4'd5;
   localparam logic [3:0] S_RM_LOAD = 4'd6;
   localparam logic [3:0] S_RM_SCAN = 4'd7;
   localparam logic [3:0] S_RM_NBR  = 4'd8;
   localparam logic [3:0] S_DONE    = 4'd9;

   // control state
   logic [3:0]              state_ff, state_in;
   logic [MAX_VERTICES-1:0] present_ff, present_in;
   logic [MAX_VERTICES-1:0] ent_vld_ff, ent_vld_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [COUNT_W-1:0]      vertex_count_ff, vertex_count_in;

   // working registers
   logic [REQ_TYPE_W-1:0]   op_ff, op_in;
   logic [VERTEX_W-1:0]     a_ff, a_in;
   logic [VERTEX_W-1:0]     b_ff, b_in;
   logic [STATUS_W-1:0]     status_ff, status_in;
   logic [CNT_W-1:0]        removed_ff, removed_in;
   logic [MAX_VERTICES-1:0] nb_row_ff, nb_row_in;
   logic [MAX_VERTICES-1:0] rm_row_ff, rm_row_in;
   logic [VX_W-1:0]         nb_idx_ff, nb_idx_in;
   logic [VX_W-1:0]         rm_idx_ff, rm_idx_in;
   logic [VX_W-1:0]         victim_ff, victim_in;
   logic                    vld_q_ff, vld_q_in;

   // response registers
   logic [STATUS_W-1:0]     rsp_status_ff;
   logic [COUNT_W-1:0]      rsp_removed_ff;
   gvd_counts_type          rsp_counts_ff;
   logic                    rsp_load;

   // vertex table and degree unit
   logic                    ram_we;
   logic [VX_W-1:0]         ram_wr_addr;
   logic [VX_W-1:0]         ram_rd_addr;
   logic [ENT_W-1:0]        ram_rd_data;
   logic [ENT_W-1:0]        entry;
   logic [MAX_VERTICES-1:0] rd_row;
   logic [DEG_W-1:0]        rd_deg;
   logic [MAX_VERTICES-1:0] row_wr;
   logic [DEG_W-1:0]        deg_wr;
   gvd_op_type              upd_op;
   logic [DEG_W-1:0]        deg_out;
   logic [CNT_W-1:0]        load_n;
   gvd_counts_type          counts;

   // decode helpers
   logic                    req_fire;
   logic [VX_W-1:0]         a_idx, b_idx;
   logic                    a_live, b_live;
   logic                    nb_last, rm_last;
   logic [3:0]              nb_next_state, rm_exit_state;
   logic [VX_W-1:0]         nb_idx_step;

   assign req_fire     = req_ch.valid && req_ch.ready;
   assign req_ch.ready = (state_ff == S_IDLE);
   assign csr_ch.ready = 1'b1;

   assign a_idx  = VX_W'(a_ff);
   assign b_idx  = VX_W'(b_ff);
   assign a_live = (32'(a_ff) < MAX_VERTICES) && present_ff[a_idx];
   assign b_live = (32'(b_ff) < MAX_VERTICES) && present_ff[b_idx];

   // clamp the configured count to the table size
   assign load_n = (32'(vertex_count_ff) > MAX_VERTICES) ? CNT_W'(MAX_VERTICES)
                                                         : CNT_W'(vertex_count_ff);

   // an entry whose valid bit is clear reads as empty with degree zero
   assign entry  = vld_q_ff ? ram_rd_data : '0;
   assign rd_row = entry[MAX_VERTICES-1:0];
   assign rd_deg = entry[ENT_W-1 -: DEG_W];

   assign nb_last       = (nb_idx_ff == VX_W'(MAX_VERTICES - 1));
   assign rm_last       = (rm_idx_ff == VX_W'(MAX_VERTICES - 1));
   assign nb_next_state = nb_last ? S_DONE : S_NB_SCAN;
   assign nb_idx_step   = nb_last ? nb_idx_ff : nb_idx_ff + VX_W'(1);
   // a single delete ends after its own walk; a neighbor delete resumes its scan
   assign rm_exit_state = (op_ff == REQ_DELETE_VERTEX) ? S_DONE : nb_next_state;

   assign vld_q_in = ent_vld_ff[ram_rd_addr];

   always_comb begin
      vertex_count_in = vertex_count_ff;
      if (csr_ch.valid && csr_ch.ready) begin
         vertex_count_in = csr_ch.vertex_count;
      end
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      a_in         = a_ff;
      b_in         = b_ff;
      status_in    = status_ff;
      removed_in   = removed_ff;
      present_in   = present_ff;
      ent_vld_in   = ent_vld_ff;
      nb_row_in    = nb_row_ff;
      rm_row_in    = rm_row_ff;
      nb_idx_in    = nb_idx_ff;
      rm_idx_in    = rm_idx_ff;
      victim_in    = victim_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      rsp_load     = 1'b0;
      ram_we       = 1'b0;
      ram_wr_addr  = a_idx;
      ram_rd_addr  = a_idx;
      row_wr       = rd_row;
      deg_wr       = deg_out;
      upd_op       = UPD_NONE;

      unique case (state_ff)
         S_IDLE: begin
            // latch the request
            if (req_fire) begin
               op_in    = req_ch.req_type;
               a_in     = req_ch.vertex;
               b_in     = req_ch.other_vertex;
               state_in = S_CHECK;
            end
         end

         S_CHECK: begin
            // the table read of the first vertex goes out here
            status_in  = STATUS_OK;
            removed_in = '0;
            unique case (op_ff)
               REQ_RESET_GRAPH: begin
                  ent_vld_in = '0;
                  for (int i = 0; i < MAX_VERTICES; i++) begin
                     present_in[i] = (CNT_W'(i) < load_n);
                  end
                  upd_op   = UPD_LOAD;
                  state_in = S_DONE;
               end
               REQ_INSERT_EDGE: begin
                  if (!a_live || !b_live) begin
                     status_in = STATUS_ABSENT;
                     state_in  = S_DONE;
                  end else if (a_ff == b_ff) begin
                     status_in = STATUS_SELF_LOOP;
                     state_in  = S_DONE;
                  end else begin
                     state_in = S_INS_A;
                  end
               end
               REQ_DELETE_VERTEX: begin
                  if (!a_live) begin
                     status_in = STATUS_ABSENT;
                     state_in  = S_DONE;
                  end else begin
                     victim_in = a_idx;
                     state_in  = S_RM_LOAD;
                  end
               end
               REQ_DELETE_NEIGHBORS: begin
                  if (!a_live) begin
                     status_in = STATUS_ABSENT;
                     state_in  = S_DONE;
                  end else begin
                     state_in = S_NB_LOAD;
                  end
               end
            endcase
         end

         S_INS_A: begin
            // a repeated edge changes nothing
            ram_rd_addr = b_idx;
            if (rd_row[b_idx]) begin
               state_in = S_DONE;
            end else begin
               upd_op             = UPD_INC;
               ram_we             = 1'b1;
               ram_wr_addr        = a_idx;
               row_wr[b_idx]      = 1'b1;
               ent_vld_in[a_idx]  = 1'b1;
               state_in           = S_INS_B;
            end
         end

         S_INS_B: begin
            upd_op            = UPD_INC;
            ram_we            = 1'b1;
            ram_wr_addr       = b_idx;
            row_wr[a_idx]     = 1'b1;
            ent_vld_in[b_idx] = 1'b1;
            state_in          = S_DONE;
         end

         S_NB_LOAD: begin
            // snapshot the row; later deletes do not disturb the scan
            nb_row_in = rd_row;
            nb_idx_in = '0;
            state_in  = S_NB_SCAN;
         end

         S_NB_SCAN: begin
            ram_rd_addr = nb_idx_ff;
            if (nb_row_ff[nb_idx_ff] && present_ff[nb_idx_ff]) begin
               victim_in = nb_idx_ff;
               state_in  = S_RM_LOAD;
            end else begin
               nb_idx_in = nb_idx_step;
               state_in  = nb_next_state;
            end
         end

         S_RM_LOAD: begin
            // drop the victim from its bucket and the table
            upd_op                = UPD_DROP;
            ent_vld_in[victim_ff] = 1'b0;
            present_in[victim_ff] = 1'b0;
            rm_row_in             = rd_row;
            rm_idx_in             = '0;
            removed_in            = removed_ff + CNT_W'(1);
            state_in              = S_RM_SCAN;
         end

         S_RM_SCAN: begin
            ram_rd_addr = rm_idx_ff;
            if (rm_row_ff[rm_idx_ff]) begin
               state_in = S_RM_NBR;
            end else if (rm_last) begin
               nb_idx_in = nb_idx_step;
               state_in  = rm_exit_state;
            end else begin
               rm_idx_in = rm_idx_ff + VX_W'(1);
            end
         end

         S_RM_NBR: begin
            // clear the victim from the neighbor's row and step its degree down
            ram_we                = 1'b1;
            ram_wr_addr           = rm_idx_ff;
            row_wr[victim_ff]     = 1'b0;
            ent_vld_in[rm_idx_ff] = 1'b1;
            if (rd_deg != '0) begin
               upd_op = UPD_DEC;
            end else begin
               deg_wr = rd_deg;
            end
            if (rm_last) begin
               nb_idx_in = nb_idx_step;
               state_in  = rm_exit_state;
            end else begin
               rm_idx_in = rm_idx_ff + VX_W'(1);
               state_in  = S_RM_SCAN;
            end
         end

         S_DONE: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_load     = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   gvd_ram #(
      .WIDTH (ENT_W),
      .DEPTH (MAX_VERTICES)
   ) u_table (
      .clock   (clock),
      .we      (ram_we),
      .wr_addr (ram_wr_addr),
      .wr_data ({deg_wr, row_wr}),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   gvd_degree_unit #(
      .MAX_VERTICES (MAX_VERTICES)
   ) u_degree (
      .clock      (clock),
      .reset      (reset),
      .upd_op     (upd_op),
      .deg_in     (rd_deg),
      .load_count (load_n),
      .deg_out    (deg_out),
      .counts     (counts)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= S_IDLE;
         present_ff      <= '0;
         ent_vld_ff      <= '0;
         rsp_valid_ff    <= 1'b0;
         vertex_count_ff <= VERTEX_COUNT_RST;
      end else begin
         state_ff        <= state_in;
         present_ff      <= present_in;
         ent_vld_ff      <= ent_vld_in;
         rsp_valid_ff    <= rsp_valid_in;
         vertex_count_ff <= vertex_count_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff      <= op_in;
      a_ff       <= a_in;
      b_ff       <= b_in;
      status_ff  <= status_in;
      removed_ff <= removed_in;
      nb_row_ff  <= nb_row_in;
      rm_row_ff  <= rm_row_in;
      nb_idx_ff  <= nb_idx_in;
      rm_idx_ff  <= rm_idx_in;
      victim_ff  <= victim_in;
      vld_q_ff   <= vld_q_in;
      if (rsp_load) begin
         rsp_status_ff  <= status_ff;
         rsp_removed_ff <= COUNT_W'(removed_ff);
         rsp_counts_ff  <= counts;
      end
   end

   assign rsp_ch.valid             = rsp_valid_ff;
   assign rsp_ch.status            = rsp_status_ff;
   assign rsp_ch.removed_count     = rsp_removed_ff;
   assign rsp_ch.present_count     = rsp_counts_ff.present;
   assign rsp_ch.degree0_count     = rsp_counts_ff.deg0;
   assign rsp_ch.degree1_count     = rsp_counts_ff.deg1;
   assign rsp_ch.degree2_count     = rsp_counts_ff.deg2;
   assign rsp_ch.degree3plus_count = rsp_counts_ff.deg3plus;

`ifndef SYNTHESIS
   a_no_self_edge: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_RM_NBR) |-> (rm_idx_ff != victim_ff))
      else $error("neighbor walk reached the deleted vertex itself");

   a_victim_gone: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_RM_SCAN) |-> !present_ff[victim_ff])
      else $error("deleted vertex still marked present during its walk");

   a_idle_no_write: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> !ram_we)
      else $error("vertex table written while idle");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_ch.valid && req_ch.ready) |=> !req_ch.ready)
      else $error("request taken while the previous one is in progress");
`endif
endmodule

### test/gvd_result_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gvd_result_checker: response predictor and comparator for the graph block
// Follows the request, response and vertex-count channels, keeps its own
// copy of the graph and expects one response per accepted request, in order.
// ----------------------------------------------------------------------------
module gvd_result_checker (
   input  logic clock,
   input  logic reset,
   gvd_req_if   req_ch,
   gvd_rsp_if   rsp_ch,
   gvd_csr_if   csr_ch,
   output int   pending,
   output int   fail_count
);
   import gvd_pkg::*;

   localparam int NV = MAX_VERTICES_DEF;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [COUNT_W-1:0]  removed;
      gvd_counts_type      counts;
   } graph_result_type;

   // shadow graph
   logic [NV-1:0]  adj_rows [NV];
   logic [NV-1:0]  live_mask;
   int unsigned    degree [NV];
   int unsigned    bucket_tally [NUM_BUCKETS];
   int unsigned    live_total;
   logic [COUNT_W-1:0] vertex_count_reg;

   graph_result_type awaited_q [$];
   graph_result_type want;

   initial begin
      fail_count = 0;
      pending    = 0;
   end

   task automatic report_error(input string msg);
      $display("%0t ns: result check: %0s", $time, msg);
      fail_count++;
   endtask

   task automatic check_field(input string name, input logic [COUNT_W-1:0] got,
                              input logic [COUNT_W-1:0] exp_val);
      if (got !== exp_val) begin
         report_error($sformatf("%0s got %0d, expected %0d", name, got, exp_val));
      end
   endtask

   function automatic int unsigned bucket_index(input int unsigned d);
      return (d >= TOP_BUCKET) ? TOP_BUCKET : d;
   endfunction

   function automatic bit is_live(input int unsigned v);
      return (v < NV) && live_mask[v];
   endfunction

   task automatic clear_graph();
      for (int i = 0; i < NV; i++) begin
         adj_rows[i] = '0;
         degree[i]   = 0;
      end
      for (int k = 0; k < NUM_BUCKETS; k++) bucket_tally[k] = 0;
      live_mask  = '0;
      live_total = 0;
   endtask

   task automatic bump_degree(input int unsigned v);
      bucket_tally[bucket_index(degree[v])]--;
      degree[v]++;
      bucket_tally[bucket_index(degree[v])]++;
   endtask

   // unlink v from every neighbor and re-bucket them
   task automatic drop_vertex(input int unsigned v);
      int unsigned old;
      bucket_tally[bucket_index(degree[v])]--;
      for (int u = 0; u < NV; u++) begin
         if (adj_rows[v][u]) begin
            old = degree[u];
            adj_rows[u][v] = 1'b0;
            if (old > 0) begin
               bucket_tally[bucket_index(old)]--;
               degree[u] = old - 1;
               bucket_tally[bucket_index(old - 1)]++;
            end
         end
      end
      adj_rows[v]  = '0;
      degree[v]    = 0;
      live_mask[v] = 1'b0;
      live_total--;
   endtask

   task automatic predict_request(input logic [REQ_TYPE_W-1:0] kind,
                                  input logic [VERTEX_W-1:0] a,
                                  input logic [VERTEX_W-1:0] b,
                                  output graph_result_type r);
      int unsigned n;
      int unsigned removed;
      logic [NV-1:0] snap;
      r.status = STATUS_OK;
      removed  = 0;
      case (kind)
         REQ_RESET_GRAPH: begin
            n = (vertex_count_reg > NV) ? NV : vertex_count_reg;
            clear_graph();
            for (int i = 0; i < n; i++) live_mask[i] = 1'b1;
            live_total      = n;
            bucket_tally[0] = n;
         end
         REQ_INSERT_EDGE: begin
            if (!is_live(a) || !is_live(b)) begin
               r.status = STATUS_ABSENT;
            end else if (a == b) begin
               r.status = STATUS_SELF_LOOP;
            end else if (!adj_rows[a][b]) begin
               adj_rows[a][b] = 1'b1;
               adj_rows[b][a] = 1'b1;
               bump_degree(a);
               bump_degree(b);
            end
         end
         REQ_DELETE_VERTEX: begin
            if (!is_live(a)) begin
               r.status = STATUS_ABSENT;
            end else begin
               drop_vertex(a);
               removed = 1;
            end
         end
         default: begin
            if (!is_live(a)) begin
               r.status = STATUS_ABSENT;
            end else begin
               snap = adj_rows[a];
               for (int i = 0; i < NV; i++) begin
                  if (snap[i] && live_mask[i]) begin
                     drop_vertex(i);
                     removed++;
                  end
               end
            end
         end
      endcase
      r.removed         = removed[COUNT_W-1:0];
      r.counts.present  = live_total[COUNT_W-1:0];
      r.counts.deg0     = bucket_tally[0][COUNT_W-1:0];
      r.counts.deg1     = bucket_tally[1][COUNT_W-1:0];
      r.counts.deg2     = bucket_tally[2][COUNT_W-1:0];
      r.counts.deg3plus = bucket_tally[TOP_BUCKET][COUNT_W-1:0];
   endtask

   always @(posedge clock) begin
      if (reset) begin
         clear_graph();
         vertex_count_reg = VERTEX_COUNT_RST;
         awaited_q.delete();
      end else begin
         // responses first: one accepted at this edge belongs to an older request
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (awaited_q.size() == 0) begin
               report_error("response with no request outstanding");
            end else begin
               want = awaited_q.pop_front();
               check_field("status", COUNT_W'(rsp_ch.status), COUNT_W'(want.status));
               check_field("removed_count", rsp_ch.removed_count, want.removed);
               check_field("present_count", rsp_ch.present_count, want.counts.present);
               check_field("degree0_count", rsp_ch.degree0_count, want.counts.deg0);
               check_field("degree1_count", rsp_ch.degree1_count, want.counts.deg1);
               check_field("degree2_count", rsp_ch.degree2_count, want.counts.deg2);
               check_field("degree3plus_count", rsp_ch.degree3plus_count,
                           want.counts.deg3plus);
            end
         end
         if (req_ch.valid && req_ch.ready) begin
            predict_request(req_ch.req_type, req_ch.vertex, req_ch.other_vertex, want);
            awaited_q = {awaited_q, want};
         end
         if (csr_ch.valid && csr_ch.ready) begin
            vertex_count_reg = csr_ch.vertex_count;
         end
      end
      pending <= awaited_q.size();
   end

endmodule

### test/tb_graph_vertex_deletion_degree_buckets.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_graph_vertex_deletion_degree_buckets: regression for the graph block
// Runs a directed opening, then random graph-building rounds under several
// vertex counts, with bursty requests and a stalling response side. The
// result checker predicts every response and counts mismatches.
// ----------------------------------------------------------------------------
module tb_graph_vertex_deletion_degree_buckets;
   import gvd_pkg::*;

   typedef struct packed {
      logic [REQ_TYPE_W-1:0] kind;
      logic [VERTEX_W-1:0]   vertex;
      logic [VERTEX_W-1:0]   other;
   } graph_request_type;

   typedef enum int {RX_STREAM, RX_COIN, RX_SPARSE} rx_mode_type;

   localparam int PHASES          = 8;
   localparam int PHASE_REQUESTS  = 200;
   localparam int LONG_HOLD       = 500;
   localparam int HOLD_INTERVAL   = 700;
   localparam int TAIL_CYCLES     = 200;

   // vertex counts per phase: extremes (0, 1, 64, above 64) plus a few between
   localparam logic [COUNT_W-1:0] PHASE_COUNTS [PHASES] =
      '{7'd64, 7'd1, 7'd127, 7'd0, 7'd23, 7'd64, 7'd2, 7'd9};

   // opening sequence, run with a vertex count of 5
   localparam int OPENING_LEN = 22;
   localparam graph_request_type OPENING [OPENING_LEN] = '{
      '{REQ_INSERT_EDGE,      6'd0,  6'd1},   // nothing present yet
      '{REQ_DELETE_VERTEX,    6'd0,  6'd0},
      '{REQ_DELETE_NEIGHBORS, 6'd63, 6'd0},
      '{REQ_RESET_GRAPH,      6'd0,  6'd63},  // other end is ignored
      '{REQ_INSERT_EDGE,      6'd0,  6'd1},
      '{REQ_INSERT_EDGE,      6'd0,  6'd2},
      '{REQ_INSERT_EDGE,      6'd3,  6'd0},   // vertex 0 reaches the top bucket
      '{REQ_INSERT_EDGE,      6'd1,  6'd2},
      '{REQ_INSERT_EDGE,      6'd1,  6'd0},   // edge already there
      '{REQ_INSERT_EDGE,      6'd2,  6'd2},   // self-loop
      '{REQ_INSERT_EDGE,      6'd4,  6'd63},  // far end not present
      '{REQ_INSERT_EDGE,      6'd63, 6'd63},  // absence wins over self-loop
      '{REQ_DELETE_NEIGHBORS, 6'd4,  6'd0},   // isolated vertex
      '{REQ_DELETE_NEIGHBORS, 6'd0,  6'd0},   // removes 1, 2 and 3
      '{REQ_DELETE_VERTEX,    6'd0,  6'd0},
      '{REQ_DELETE_VERTEX,    6'd0,  6'd0},   // already gone
      '{REQ_RESET_GRAPH,      6'd63, 6'd0},
      '{REQ_INSERT_EDGE,      6'd4,  6'd3},
      '{REQ_INSERT_EDGE,      6'd4,  6'd2},
      '{REQ_INSERT_EDGE,      6'd4,  6'd1},
      '{REQ_DELETE_VERTEX,    6'd4,  6'd0},   // re-buckets three neighbors
      '{REQ_DELETE_NEIGHBORS, 6'd1,  6'd0}    // no neighbors left
   };

   logic clock = 1'b0;
   logic reset;

   int results_pending;
   int mismatch_total;
   int burst_left = 0;

   gvd_req_if req_if ();
   gvd_rsp_if rsp_if ();
   gvd_csr_if csr_if ();

   graph_vertex_deletion_degree_buckets dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_if),
      .rsp_ch (rsp_if),
      .csr_ch (csr_if)
   );

   gvd_result_checker result_check (
      .clock      (clock),
      .reset      (reset),
      .req_ch     (req_if),
      .rsp_ch     (rsp_if),
      .csr_ch     (csr_if),
      .pending    (results_pending),
      .fail_count (mismatch_total)
   );

   // 12 ns period
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Offer one request, holding it until accepted. Requests go out in bursts;
   // at the end of a burst drop valid for a random gap, or run straight on.
   task automatic offer_request(input graph_request_type item);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         if (gap > 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 24);
      end
      burst_left--;
      req_if.valid        <= 1'b1;
      req_if.req_type     <= item.kind;
      req_if.vertex       <= item.vertex;
      req_if.other_vertex <= item.other;
      do @(posedge clock); while (!req_if.ready);
   endtask

   // Stop sending and wait until every outstanding request has its response.
   // The checker's pending count is registered, so step the clock before reading it.
   task automatic drain_requests();
      req_if.valid <= 1'b0;
      burst_left = 0;
      @(posedge clock);
      while (results_pending != 0) @(posedge clock);
   endtask

   // Write the vertex count with the block idle.
   task automatic write_vertex_count(input logic [COUNT_W-1:0] count);
      drain_requests();
      csr_if.valid        <= 1'b1;
      csr_if.vertex_count <= count;
      do @(posedge clock); while (!csr_if.ready);
      csr_if.valid <= 1'b0;
   endtask

   // Mostly a vertex inside the active span, now and then any vertex.
   function automatic logic [VERTEX_W-1:0] pick_vertex(input int span);
      if ($urandom_range(0, 6) == 0) return VERTEX_W'($urandom_range(0, 63));
      return VERTEX_W'($urandom_range(0, span - 1));
   endfunction

   // One request of a graph-building round; the tail is pure noise.
   function automatic graph_request_type pick_request(input int span);
      graph_request_type item;
      int roll;
      roll = $urandom_range(0, 99);
      item.vertex = pick_vertex(span);
      item.other  = pick_vertex(span);
      if (roll < 55) begin
         item.kind = REQ_INSERT_EDGE;
      end else if (roll < 72) begin
         item.kind  = REQ_DELETE_VERTEX;
         item.other = VERTEX_W'($urandom_range(0, 63));
      end else if (roll < 84) begin
         item.kind  = REQ_DELETE_NEIGHBORS;
         item.other = VERTEX_W'($urandom_range(0, 63));
      end else if (roll < 88) begin
         item.kind = REQ_RESET_GRAPH;
      end else begin
         item.kind   = REQ_TYPE_W'($urandom_range(0, 3));
         item.vertex = VERTEX_W'($urandom_range(0, 63));
         item.other  = VERTEX_W'($urandom_range(0, 63));
      end
      return item;
   endfunction

   // Stimulus: reset, opening sequence, then random phases.
   initial begin
      graph_request_type item;
      int lim;
      int span;
      int sent;
      int round_left;

      reset               <= 1'b1;
      req_if.valid        <= 1'b0;
      req_if.req_type     <= REQ_RESET_GRAPH;
      req_if.vertex       <= '0;
      req_if.other_vertex <= '0;
      csr_if.valid        <= 1'b0;
      csr_if.vertex_count <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      write_vertex_count(7'd5);
      for (int i = 0; i < OPENING_LEN; i++) offer_request(OPENING[i]);

      for (int phase = 0; phase < PHASES; phase++) begin
         write_vertex_count(PHASE_COUNTS[phase]);
         lim  = (int'(PHASE_COUNTS[phase]) > MAX_VERTICES_DEF) ? MAX_VERTICES_DEF
                                                             : int'(PHASE_COUNTS[phase]);
         sent = 0;
         while (sent < PHASE_REQUESTS) begin
            // a round: usually a fresh graph, then edges and deletions on it
            if ($urandom_range(0, 9) != 0) begin
               item.kind   = REQ_RESET_GRAPH;
               item.vertex = VERTEX_W'($urandom_range(0, 63));
               item.other  = VERTEX_W'($urandom_range(0, 63));
               offer_request(item);
               sent++;
            end
            // a narrow span gives dense graphs and high-degree vertices
            if (lim == 0) begin
               span = 64;
            end else if ($urandom_range(0, 1) == 0) begin
               span = $urandom_range(1, (lim < 8) ? lim : 8);
            end else begin
               span = $urandom_range(1, lim);
            end
            round_left = $urandom_range(4, 60);
            while (round_left > 0 && sent < PHASE_REQUESTS) begin
               offer_request(pick_request(span));
               sent++;
               round_left--;
               // in phase 2, hold the sender once mid-phase until the block is empty
               if (phase == 2 && sent == PHASE_REQUESTS / 2) drain_requests();
            end
         end
      end

      drain_requests();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatch_total == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

   // Response side: switch among stall patterns, and at intervals hold off
   // for a long stretch so the block backs up and stalls its request side.
   initial begin
      rx_mode_type mode;
      int mode_left;
      int hold_left;
      int taken;
      int next_hold;

      mode      = RX_STREAM;
      mode_left = 0;
      hold_left = 0;
      taken     = 0;
      next_hold = 400;
      rsp_if.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_if.valid && rsp_if.ready) taken++;
         if (hold_left > 0) begin
            hold_left--;
            rsp_if.ready <= 1'b0;
         end else if (taken >= next_hold) begin
            hold_left = LONG_HOLD;
            next_hold += HOLD_INTERVAL;
            rsp_if.ready <= 1'b0;
         end else begin
            if (mode_left == 0) begin
               mode      = rx_mode_type'($urandom_range(0, 2));
               mode_left = $urandom_range(20, 200);
            end
            mode_left--;
            case (mode)
               RX_STREAM: rsp_if.ready <= 1'b1;
               RX_COIN:   rsp_if.ready <= 1'($urandom_range(0, 1));
               default:   rsp_if.ready <= ($urandom_range(0, 3) == 0);
            endcase
         end
      end
   end

   // Watchdog: far beyond the slowest legal run.
   initial begin
      #400_000_000;
      $display("Regression FAIL");
      $finish;
   end

endmodule
